/* rtl/url_signature_risk_scorer_assert.svh */
// Assertion macros shared by the scorer RTL.
// Each macro expects clk and arst_n in scope.
`ifndef URL_SIGNATURE_RISK_SCORER_ASSERT_SVH
`define URL_SIGNATURE_RISK_SCORER_ASSERT_SVH

// Same-cycle implication.
`define USRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define USRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/usrs_pkg.sv */
`default_nettype none
package usrs_pkg;

	// History window depth in bytes (18 .. 63)
	localparam int WINDOW_DEPTH = 18;

	typedef logic [7:0] byte_t;
	typedef logic [WINDOW_DEPTH-1:0][7:0] win_t;

	// Signature text, right-justified: byte 0 is the last character
	localparam int SIG_MAX_LEN  = 19;
	localparam int DOMAIN_COUNT = 8;
	localparam int WORD_COUNT   = 6;
	typedef logic [SIG_MAX_LEN*8-1:0] sig_text_t;
	typedef logic [4:0] sig_len_t;

	localparam sig_text_t DOMAIN_TEXT [DOMAIN_COUNT] = '{
		".xyz", ".tk", ".show", ".cf", ".ga", ".ml", ".top", ".gq"
	};
	localparam sig_len_t DOMAIN_LEN [DOMAIN_COUNT] = '{
		5'd4, 5'd3, 5'd5, 5'd3, 5'd3, 5'd3, 5'd4, 5'd3
	};
	localparam sig_text_t WORD_TEXT [WORD_COUNT] = '{
		"g00gle", "faceb00k", "amaz0n", "pay-pal", "bank-login",
		"secure-verification"
	};
	localparam sig_len_t WORD_LEN [WORD_COUNT] = '{
		5'd6, 5'd8, 5'd6, 5'd7, 5'd10, 5'd19
	};

	// Configuration register indexes
	localparam logic [1:0] CFG_DASH_LIMIT = 2'd0;
	localparam logic [1:0] CFG_CAUTION    = 2'd1;
	localparam logic [1:0] CFG_DANGER     = 2'd2;

	// Risk levels
	localparam logic [1:0] LEVEL_SAFE       = 2'd0;
	localparam logic [1:0] LEVEL_SUSPICIOUS = 2'd1;
	localparam logic [1:0] LEVEL_DANGEROUS  = 2'd2;

	// Score weights and cap
	localparam logic [4:0] W_DOMAIN = 5'd4;
	localparam logic [4:0] W_WORD   = 5'd4;
	localparam logic [4:0] W_DASH   = 5'd3;
	localparam logic [4:0] W_AT     = 5'd3;
	localparam logic [4:0] W_IP     = 5'd5;
	localparam logic [3:0] SCORE_MAX = 4'd10;

	// One result
	typedef struct packed {
		logic [3:0] score;
		logic [1:0] level;
		logic       domain;
		logic       word;
		logic       dash;
		logic       at;
		logic       ip;
	} result_t;

endpackage
`default_nettype wire

/* rtl/usrs_cell.sv */
`default_nettype none
module usrs_cell (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            adv,
	input  wire            flush,
	input  usrs_pkg::byte_t d,
	output usrs_pkg::byte_t q
);
	import usrs_pkg::*;

	byte_t byte_q;

	// One window slot: take the neighbor's byte, or clear at end of URL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (adv) begin
			byte_q <= flush ? '0 : d;
		end
	end

	assign q = byte_q;

endmodule
`default_nettype wire

/* rtl/usrs_match.sv */
`default_nettype none
module usrs_match (
	input  usrs_pkg::byte_t cur,
	input  usrs_pkg::win_t  win,
	output logic            domain_match,
	output logic            word_match
);
	import usrs_pkg::*;

	// Signature ends at the current byte; earlier bytes come from the window
	function automatic logic sig_hit(input sig_text_t text, input sig_len_t len,
			input byte_t c, input win_t w);
		logic ok;
		ok = (text[7:0] == c);
		for (int k = 1; k < SIG_MAX_LEN; k++) begin
			if (k < int'(len)) begin
				ok = ok & (text[k*8 +: 8] == w[k-1]);
			end
		end
		return ok;
	endfunction

	always_comb begin
		domain_match = 1'b0;
		for (int s = 0; s < DOMAIN_COUNT; s++) begin
			if (sig_hit(DOMAIN_TEXT[s], DOMAIN_LEN[s], cur, win)) begin
				domain_match = 1'b1;
			end
		end
	end

	always_comb begin
		word_match = 1'b0;
		for (int s = 0; s < WORD_COUNT; s++) begin
			if (sig_hit(WORD_TEXT[s], WORD_LEN[s], cur, win)) begin
				word_match = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/usrs_quad.sv */
`default_nettype none
module usrs_quad (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             adv,
	input  wire             flush,
	input  usrs_pkg::byte_t c,
	output logic            ip_now
);
	import usrs_pkg::*;

	logic [1:0] groups_q, groups_n;
	logic [2:0] run_q, run_n;
	logic       bound_q, bound_n;
	logic       seen_q, seen_n;
	logic       is_dig, is_wrd, run_ok, done_pre, done_post;

	// Character classes
	assign is_dig = (c >= "0") && (c <= "9");
	assign is_wrd = is_dig || ((c >= "A") && (c <= "Z")) ||
		((c >= "a") && (c <= "z")) || (c == "_");

	assign run_ok   = (run_q >= 3'd1) && (run_q <= 3'd3) && bound_q;
	assign done_pre = (groups_q == 2'd3) && run_ok;

	// Dotted chain tracking
	always_comb begin
		groups_n = groups_q;
		run_n    = run_q;
		bound_n  = bound_q;
		seen_n   = seen_q;
		if (is_dig) begin
			if (run_q < 3'd4) begin
				run_n = run_q + 3'd1;
			end
		end else begin
			if (!is_wrd && done_pre) begin
				seen_n = 1'b1;
			end
			if (c == ".") begin
				if (run_ok) begin
					if (groups_q != 2'd3) begin
						groups_n = groups_q + 2'd1;
					end
				end else begin
					groups_n = 2'd0;
				end
				bound_n = 1'b1;
			end else begin
				groups_n = 2'd0;
				bound_n  = !is_wrd;
			end
			run_n = 3'd0;
		end
	end

	// End of URL also closes a final run
	assign done_post = (groups_n == 2'd3) && (run_n >= 3'd1) && (run_n <= 3'd3) && bound_n;
	assign ip_now    = seen_n | done_post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_q <= 2'd0;
			run_q    <= 3'd0;
			bound_q  <= 1'b1;
			seen_q   <= 1'b0;
		end else if (adv) begin
			if (flush) begin
				groups_q <= 2'd0;
				run_q    <= 3'd0;
				bound_q  <= 1'b1;
				seen_q   <= 1'b0;
			end else begin
				groups_q <= groups_n;
				run_q    <= run_n;
				bound_q  <= bound_n;
				seen_q   <= seen_n;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/url_signature_risk_scorer.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  url_byte, last_byte
// out      out_valid/out_stall  risk_score, risk_level, domain_hit .. ip_hit
// cfg      cfg_we               cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; every signature is compared
// against the cell chain in the cycle the byte arrives, so throughput is
// set by the combinational match. A URL's result is registered in out_q or
// the skid slot. Reset clears the window, the flags and loads the register
// defaults; no clearing pass. An output skid slot lets input run while a
// result is stalled; in_stall rises only when both result slots are full.
`default_nettype none
module url_signature_risk_scorer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] url_byte,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [3:0] risk_score,
	output logic [1:0] risk_level,
	output logic       domain_hit,
	output logic       word_hit,
	output logic       dash_hit,
	output logic       at_hit,
	output logic       ip_hit,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [7:0] cfg_data
);
	import usrs_pkg::*;

	logic       accept, produce;
	logic [7:0] dash_limit_q;
	logic [3:0] caution_q, danger_q;
	win_t       win;
	logic       dom_match, word_match, ip_now;
	logic       domain_q, word_q, at_q;
	logic [7:0] dash_q, dash_n;
	logic       dom_n, word_n, at_n, dash_flag;
	logic [4:0] score_raw;
	logic [3:0] score;
	result_t    res_n, out_q, skid_q;
	logic       out_valid_q, skid_valid_q;

	assign accept  = in_valid && !in_stall;
	assign produce = accept && last_byte;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_limit_q <= 8'd2;
			caution_q    <= 4'd5;
			danger_q     <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DASH_LIMIT: dash_limit_q <= cfg_data;
				CFG_CAUTION:    caution_q    <= cfg_data[3:0];
				CFG_DANGER:     danger_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Byte window: chain of cells, newest byte in cell 0
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_win
		byte_t cell_d;
		if (i == 0) begin : g_head
			assign cell_d = url_byte;
		end else begin : g_link
			assign cell_d = win[i-1];
		end
		usrs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (accept),
			.flush  (last_byte),
			.d      (cell_d),
			.q      (win[i])
		);
	end

	usrs_match u_match (
		.cur          (url_byte),
		.win          (win),
		.domain_match (dom_match),
		.word_match   (word_match)
	);

	usrs_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (accept),
		.flush  (last_byte),
		.c      (url_byte),
		.ip_now (ip_now)
	);

	// Sticky flags including the current byte
	assign dom_n  = domain_q | dom_match;
	assign word_n = word_q | word_match;
	assign at_n   = at_q | (url_byte == "@");
	assign dash_n = ((url_byte == "-" || url_byte == "_") && dash_q != 8'hFF) ?
		dash_q + 8'd1 : dash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_q <= 1'b0;
			word_q   <= 1'b0;
			at_q     <= 1'b0;
			dash_q   <= 8'd0;
		end else if (accept) begin
			if (last_byte) begin
				domain_q <= 1'b0;
				word_q   <= 1'b0;
				at_q     <= 1'b0;
				dash_q   <= 8'd0;
			end else begin
				domain_q <= dom_n;
				word_q   <= word_n;
				at_q     <= at_n;
				dash_q   <= dash_n;
			end
		end
	end

	// Score and level
	assign dash_flag = dash_n > dash_limit_q;
	assign score_raw = (dom_n ? W_DOMAIN : 5'd0) + (word_n ? W_WORD : 5'd0) +
		(dash_flag ? W_DASH : 5'd0) + (at_n ? W_AT : 5'd0) + (ip_now ? W_IP : 5'd0);
	assign score = (score_raw > 5'(SCORE_MAX)) ? SCORE_MAX : score_raw[3:0];

	always_comb begin
		res_n.score  = score;
		res_n.domain = dom_n;
		res_n.word   = word_n;
		res_n.dash   = dash_flag;
		res_n.at     = at_n;
		res_n.ip     = ip_now;
		priority if (score >= danger_q) begin
			res_n.level = LEVEL_DANGEROUS;
		end else if (score >= caution_q) begin
			res_n.level = LEVEL_SUSPICIOUS;
		end else begin
			res_n.level = LEVEL_SAFE;
		end
	end

	// Output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (produce) begin
				out_q <= res_n;
			end
		end else if (produce) begin
			skid_q <= res_n;
		end
	end

	assign in_stall   = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign risk_score = out_q.score;
	assign risk_level = out_q.level;
	assign domain_hit = out_q.domain;
	assign word_hit   = out_q.word;
	assign dash_hit   = out_q.dash;
	assign at_hit     = out_q.at;
	assign ip_hit     = out_q.ip;

	// Checks
`include "url_signature_risk_scorer_assert.svh"
	`USRS_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid slot full with output empty")
	`USRS_ASSERT_NEXT(a_stalled_result_parks, produce && out_valid_q && out_stall, skid_valid_q, "stalled request lost")
	`USRS_ASSERT_NEXT(a_window_cleared, produce, win == '0, "window not cleared after last byte")
	`USRS_ASSERT_NOW(a_danger_level, out_valid_q && risk_level == LEVEL_DANGEROUS, risk_score >= danger_q, "dangerous level below threshold")

endmodule
`default_nettype wire
